/* src/sha1_pkg.sv */
package sha1_pkg;

    localparam int WORD_W          = 32;
    localparam int BLOCK_WORDS     = 16;
    localparam int ROUNDS          = 80;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Initial chaining words, word 0 in the lowest slot.
    localparam logic [4:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [2:0] LAST_INDEX = 3'd4;

    // Word positions of the 64-bit length inside the final block.
    localparam logic [3:0] LEN_HI_POS = 4'(BLOCK_WORDS - 2);
    localparam logic [3:0] LEN_LO_POS = 4'(BLOCK_WORDS - 1);

    typedef struct packed {
        logic              final_blk;  // last word of the last block of a message
        logic [WORD_W-1:0] word;
    } t_qword;

endpackage

/* src/sha1_front.sv */
module sha1_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  logic [7:0]      i_data_byte,
    output logic            o_push,
    output sha1_pkg::t_qword o_push_data,
    input  logic            i_full
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_PAD, F_LEN_LO} t_fstate;

    t_fstate           r_state, n_state;
    logic [WORD_W-1:0] r_word, n_word;
    logic [1:0]        r_bcnt, n_bcnt;
    logic [3:0]        r_wpos, n_wpos;
    logic              r_extra, n_extra;
    logic [60:0]       r_bytes, n_bytes;

    logic              accept;
    logic [7:0]        ins_byte;
    logic [WORD_W-1:0] merged;
    logic [63:0]       bit_len;

    assign o_ready = (r_state == F_IDLE) && !i_full;
    assign accept  = i_valid && o_ready;
    assign bit_len = {r_bytes, 3'b000};

    assign ins_byte = (i_kind == KIND_END) ? PAD_BYTE : i_data_byte;

    // Bytes fill a word from the most significant end.
    always_comb begin
        case (r_bcnt)
            2'd0:    merged = r_word | {ins_byte, 24'h0};
            2'd1:    merged = r_word | {8'h0, ins_byte, 16'h0};
            2'd2:    merged = r_word | {16'h0, ins_byte, 8'h0};
            default: merged = r_word | {24'h0, ins_byte};
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_bcnt      = r_bcnt;
        n_wpos      = r_wpos;
        n_extra     = r_extra;
        n_bytes     = r_bytes;
        o_push      = 1'b0;
        o_push_data = '0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    o_push_data.word = merged;
                    if (i_kind == KIND_BYTE) begin
                        n_bytes = r_bytes + 61'd1;
                        n_bcnt  = r_bcnt + 2'd1;
                        if (r_bcnt == 2'd3) begin
                            o_push = 1'b1;
                            n_word = '0;
                            n_wpos = r_wpos + 4'd1;
                        end else begin
                            n_word = merged;
                        end
                    end else begin
                        o_push  = 1'b1;
                        n_word  = '0;
                        n_bcnt  = 2'd0;
                        n_wpos  = r_wpos + 4'd1;
                        // No room for the length after the pad word: one more block.
                        n_extra = (r_wpos == LEN_HI_POS);
                        n_state = F_PAD;
                    end
                end
            end
            F_PAD: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_wpos = r_wpos + 4'd1;
                    if ((r_wpos == LEN_HI_POS) && !r_extra) begin
                        o_push_data.word = bit_len[63:32];
                        n_state          = F_LEN_LO;
                    end else if (r_wpos == LEN_LO_POS) begin
                        n_extra = 1'b0;
                    end
                end
            end
            F_LEN_LO: begin
                if (!i_full) begin
                    o_push                = 1'b1;
                    o_push_data.word      = bit_len[31:0];
                    o_push_data.final_blk = 1'b1;
                    n_wpos                = '0;
                    n_bytes               = '0;
                    n_state               = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_word  <= '0;
            r_bcnt  <= '0;
            r_wpos  <= '0;
            r_extra <= 1'b0;
            r_bytes <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_bcnt  <= n_bcnt;
            r_wpos  <= n_wpos;
            r_extra <= n_extra;
            r_bytes <= n_bytes;
        end
    end

endmodule

/* src/sha1_queue.sv */
module sha1_queue #(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sha1_pkg::t_qword i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output sha1_pkg::t_qword o_data,
    input  logic             i_pop
);
    import sha1_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qword             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* src/sha1_core.sv */
module sha1_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  sha1_pkg::t_qword            i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sha1_pkg::WORD_W-1:0] o_digest_word,
    output logic [2:0]                  o_word_index,
    output logic                        o_last_word
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_OUT} t_bstate;

    t_bstate                r_state;
    logic [WORD_W-1:0]      r_w [BLOCK_WORDS];
    logic [WORD_W-1:0]      r_a, r_b, r_c, r_d, r_e;
    logic [4:0][WORD_W-1:0] r_h;
    logic [6:0]             r_cnt;
    logic                   r_final;
    logic [2:0]             r_idx;

    logic [WORD_W-1:0]      f_val, k_val, t_val, w_new, w_x;

    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + r_w[0] + k_val;
    // The window holds w[t..t+15]; the word shifted in is w[t+16].
    assign w_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_new = {w_x[30:0], w_x[31]};

    assign o_q_pop       = (r_state == B_LOAD) && i_q_valid;
    assign o_valid       = (r_state == B_OUT);
    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            r_h     <= H_INIT;
            r_cnt   <= '0;
            r_final <= 1'b0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                B_LOAD: begin
                    if (i_q_valid) begin
                        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                        r_w[BLOCK_WORDS-1] <= i_q_data.word;
                        if (r_cnt[3:0] == 4'(BLOCK_WORDS - 1)) begin
                            r_final <= i_q_data.final_blk;
                            r_cnt   <= '0;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_e     <= r_h[4];
                            r_state <= B_ROUND;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                B_ROUND: begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[BLOCK_WORDS-1] <= w_new;
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= t_val;
                    if (r_cnt == 7'(ROUNDS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= B_ADD;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                B_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_idx  <= '0;
                    r_state <= r_final ? B_OUT : B_LOAD;
                end
                B_OUT: begin
                    if (i_ready) begin
                        if (r_idx == LAST_INDEX) begin
                            r_h     <= H_INIT;
                            r_idx   <= '0;
                            r_state <= B_LOAD;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= B_LOAD;
            endcase
        end
    end

endmodule

/* src/sha1_message_hasher.sv */
// Channel   Direction  tdata                                   tuser / tlast
// s_axis    in         [7:0] data_byte                         tuser[0] kind (1 = end)
// m_axis    out        [31:0] digest_word, [34:32] word_index  tlast = last_word
//
// Message bytes are packed into words that wait in a word queue (QUEUE_DEPTH words)
// ahead of the compression unit.
// For each 64-byte block the compression unit loads the schedule window, runs the
// 80 rounds and adds the working words into the chaining words.
// With the pad byte in word p, an end item keeps the front busy while it makes the
// zero words and the length (in one more block when p is 14 or 15); the unit then
// compresses one or two blocks and gives five digest items, one per cycle while
// m_axis_tready is high.
// The input stalls while the word queue is full or the pad words are being made.
// Reset is synchronous and active low.
module sha1_message_hasher #(
    parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);
    import sha1_pkg::*;

    t_qword            push_data, q_data;
    logic              push, q_full, q_valid, q_pop;
    logic [WORD_W-1:0] digest_word;
    logic [2:0]        word_index;

    sha1_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser[0]),
        .i_data_byte (i_s_axis_tdata),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (q_full)
    );

    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    sha1_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_digest_word (digest_word),
        .o_word_index  (word_index),
        .o_last_word   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, word_index, digest_word};

endmodule

/* src/sha1_checker.sv */
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import sha1_pkg::*;

    // A stalled digest item holds its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("digest item changed while stalled");

    // tlast marks exactly the fifth digest word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[34:32] == LAST_INDEX)))
        else $error("tlast does not match word index");

    // The five digest words leave back to back, in order.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid &&
            (o_m_axis_tdata[34:32] == 3'($past(o_m_axis_tdata[34:32]) + 3'd1)))
        else $error("digest words out of sequence");

    // No digest item right after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (.*);

/* test/testbench.sv */
module testbench;

    import sha1_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Tracks the hash state of the message in flight and holds the digest words still owed.
    class sha1_digest_tracker;
        logic [31:0]  chain [5];
        logic [7:0]   block_bytes [64];
        int unsigned  fill;
        logic [63:0]  bit_count;
        t_digest_word expected_words [$];
        int           errors;
        int           words_checked;

        function new();
            errors = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
            fill = 0;
            bit_count = '0;
        endfunction

        function void compress_block();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++) begin
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            end
            for (int i = 16; i < 80; i++) begin
                t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {t[30:0], t[31]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_0;
                end else if (i < 40) begin
                    f = b ^ c ^ d;
                    k = K_1;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_2;
                end else begin
                    f = b ^ c ^ d;
                    k = K_3;
                end
                t = {a[26:0], a[31:27]} + f + e + w[i] + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb_item(logic kind, logic [7:0] value);
            t_digest_word item;
            if (kind == KIND_BYTE) begin
                block_bytes[fill] = value;
                fill++;
                bit_count += 64'd8;
                if (fill == 64) begin
                    compress_block();
                    fill = 0;
                end
            end else begin
                block_bytes[fill] = PAD_BYTE;
                fill++;
                // No room left for the length field, so it goes into an extra block.
                if (fill > 56) begin
                    while (fill < 64) begin
                        block_bytes[fill] = 8'h00;
                        fill++;
                    end
                    compress_block();
                    fill = 0;
                end
                while (fill < 56) begin
                    block_bytes[fill] = 8'h00;
                    fill++;
                end
                for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_count[63-8*i -: 8];
                compress_block();
                for (int i = 0; i < 5; i++) begin
                    item.word  = chain[i];
                    item.index = 3'(i);
                    item.last  = (3'(i) == LAST_INDEX);
                    expected_words.push_back(item);
                end
                restart();
            end
        endfunction

        function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
            t_digest_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected digest item: word %h index %0d last %0b", word, index, last);
                errors++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (word !== want.word) begin
                    $error("digest_word: expected %h, actual %h", want.word, word);
                    errors++;
                end
                if (index !== want.index) begin
                    $error("word_index: expected %0d, actual %0d", want.index, index);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last_word: expected %0b, actual %0b", want.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic [0:0]  s_kind = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [39:0] m_data;
    logic        m_last;

    sha1_digest_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    int messages_sent = 0;

    sha1_message_hasher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always #10 i_clk = ~i_clk;

    task automatic send_item(input logic kind, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        s_kind  <= kind;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        tracker.absorb_item(kind, value);
        items_sent++;
        if (kind == KIND_END) messages_sent++;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_item(KIND_BYTE, random_byte());
        send_item(KIND_END, 8'($urandom));
    endtask

    // Favors short messages and lengths around the padding and block boundaries.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom_range(8);
        if (sel < 7) begin
            case ($urandom_range(8))
                0: return 54;
                1: return 55;
                2: return 56;
                3: return 57;
                4: return 63;
                5: return 64;
                6: return 65;
                7: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(140);
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: checks each accepted digest item and picks the next ready level.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready) begin
                tracker.check_digest_word(m_data[31:0], m_data[34:32], m_last);
            end
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int phase_items;
        int idle_pct [4];
        int stall_pct [4];
        idle_pct  = '{0, 79, 0, 11};
        stall_pct = '{0, 0, 79, 11};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, "abc", extreme byte values, ignored data on the end item.
        send_item(KIND_END, 8'h00);
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_END, 8'hFF);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_END, 8'h5A);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_END, 8'hA5);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hA5);
        send_item(KIND_BYTE, 8'h5A);
        send_item(KIND_END, 8'h00);
        send_item(KIND_END, 8'hFF);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_items = items_sent;
            while (items_sent - phase_items < 25) begin
                send_message(pick_length());
            end
            wait_drained();
        end

        // Receiver holds off for a long stretch while short messages keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 1500;
        for (int i = 0; i < 8; i++) send_message($urandom_range(10));
        wait_drained();

        repeat (300) @(posedge i_clk);
        $display("Hashed %0d messages from %0d input items; %0d digest words checked.",
                 messages_sent, items_sent, tracker.words_checked);
        $display("Covered padding boundaries, multi-block messages and all idle mixes.");
        if (tracker.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("testbench failed");
        $finish;
    end

endmodule
